// File: src/iad_pkg.sv
// ----------------------------------------------------------------------------
// iad_pkg
// Shared types and constants of the integer atan2 unit.
// ----------------------------------------------------------------------------
package iad_pkg;

	// Default width of one coordinate.
	localparam int COORD_WIDTH_DEF = 16;

	// The quotient of min * 45 / max never exceeds 45, so six bits hold it.
	localparam int QUOT_W  = 6;
	// Width of the angle result.
	localparam int ANGLE_W = 9;
	// Width of the corrected and mirrored angle, 0 to 90.
	localparam int OCT_W   = 7;

	// Octant scale and quadrant placement.
	localparam logic [OCT_W-1:0]   DEG_90  = 7'd90;
	localparam logic [ANGLE_W-1:0] DEG_180 = 9'd180;
	localparam logic [ANGLE_W-1:0] DEG_360 = 9'd360;

	// Correction thresholds.
	localparam logic [QUOT_W-1:0] SPLIT   = 6'd22;
	localparam logic [QUOT_W-1:0] LO_TH_0 = 6'd2;
	localparam logic [QUOT_W-1:0] LO_TH_1 = 6'd6;
	localparam logic [QUOT_W-1:0] LO_TH_2 = 6'd10;
	localparam logic [QUOT_W-1:0] LO_TH_3 = 6'd15;
	localparam logic [QUOT_W-1:0] HI_TH_0 = 6'd44;
	localparam logic [QUOT_W-1:0] HI_TH_1 = 6'd41;
	localparam logic [QUOT_W-1:0] HI_TH_2 = 6'd37;
	localparam logic [QUOT_W-1:0] HI_TH_3 = 6'd32;

	// Sign and octant information that travels beside the division.
	typedef struct packed {
		logic x_neg;
		logic y_neg;
		logic mirror;
	} iad_flags_t;

endpackage

// File: src/iad_front.sv
// ----------------------------------------------------------------------------
// iad_front
// Two stages: magnitudes and ordering, then the dividend min * 45.
// ----------------------------------------------------------------------------
module iad_front #(
	parameter int COORD_WIDTH = iad_pkg::COORD_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 in_valid,
	input  logic signed [COORD_WIDTH-1:0]        x_value,
	input  logic signed [COORD_WIDTH-1:0]        y_value,
	output logic                                 out_valid,
	output logic [COORD_WIDTH+iad_pkg::QUOT_W-1:0] num,
	output logic [COORD_WIDTH-1:0]               div,
	output iad_pkg::iad_flags_t                  flags
);

	localparam int NUM_W = COORD_WIDTH + iad_pkg::QUOT_W;

	logic [COORD_WIDTH-1:0] ax;
	logic [COORD_WIDTH-1:0] ay;
	logic                   x_gt;

	// Negation in COORD_WIDTH bits gives the exact magnitude of the most
	// negative value when read as unsigned.
	assign ax   = x_value[COORD_WIDTH-1] ? (~x_value + 1'b1) : x_value;
	assign ay   = y_value[COORD_WIDTH-1] ? (~y_value + 1'b1) : y_value;
	assign x_gt = ax > ay;

	logic                   valid_s1;
	logic [COORD_WIDTH-1:0] min_s1;
	logic [COORD_WIDTH-1:0] max_s1;
	iad_pkg::iad_flags_t    flags_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			min_s1          <= x_gt ? ay : ax;
			max_s1          <= x_gt ? ax : ay;
			flags_s1.x_neg  <= x_value[COORD_WIDTH-1];
			flags_s1.y_neg  <= y_value[COORD_WIDTH-1];
			flags_s1.mirror <= x_gt;
		end
	end

	// Times 45 as 32 + 8 + 4 + 1.
	logic [NUM_W-1:0] min_ext;
	logic [NUM_W-1:0] num_next;

	assign min_ext  = {{iad_pkg::QUOT_W{1'b0}}, min_s1};
	assign num_next = (min_ext << 5) + (min_ext << 3) + (min_ext << 2) + min_ext;

	logic                   valid_s2;
	logic [NUM_W-1:0]       num_s2;
	logic [COORD_WIDTH-1:0] div_s2;
	iad_pkg::iad_flags_t    flags_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s2   <= num_next;
			div_s2   <= max_s1;
			flags_s2 <= flags_s1;
		end
	end

	assign out_valid = valid_s2;
	assign num       = num_s2;
	assign div       = div_s2;
	assign flags     = flags_s2;

endmodule

// File: src/iad_cell.sv
// ----------------------------------------------------------------------------
// iad_cell
// One restoring division step that settles one quotient bit.
// ----------------------------------------------------------------------------
module iad_cell #(
	parameter int COORD_WIDTH = iad_pkg::COORD_WIDTH_DEF,
	parameter int BIT_POS     = 0
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic                                   in_valid,
	input  logic [COORD_WIDTH+iad_pkg::QUOT_W-1:0] rem_in,
	input  logic [COORD_WIDTH-1:0]                 div_in,
	input  logic [iad_pkg::QUOT_W-1:0]             quot_in,
	input  iad_pkg::iad_flags_t                    flags_in,
	output logic                                   out_valid,
	output logic [COORD_WIDTH+iad_pkg::QUOT_W-1:0] rem_out,
	output logic [COORD_WIDTH-1:0]                 div_out,
	output logic [iad_pkg::QUOT_W-1:0]             quot_out,
	output iad_pkg::iad_flags_t                    flags_out
);

	localparam int NUM_W = COORD_WIDTH + iad_pkg::QUOT_W;

	logic [NUM_W-1:0]             trial;
	logic                         fits;
	logic [NUM_W-1:0]             rem_next;
	logic [iad_pkg::QUOT_W-1:0]   quot_next;

	assign trial = {{iad_pkg::QUOT_W{1'b0}}, div_in} << BIT_POS;
	assign fits  = rem_in >= trial;

	always_comb begin
		rem_next  = rem_in;
		quot_next = quot_in;
		if (fits) begin
			rem_next           = rem_in - trial;
			quot_next[BIT_POS] = 1'b1;
		end
	end

	logic                       valid_q;
	logic [NUM_W-1:0]           rem_q;
	logic [COORD_WIDTH-1:0]     div_q;
	logic [iad_pkg::QUOT_W-1:0] quot_q;
	iad_pkg::iad_flags_t        flags_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q   <= rem_next;
			div_q   <= div_in;
			quot_q  <= quot_next;
			flags_q <= flags_in;
		end
	end

	assign out_valid = valid_q;
	assign rem_out   = rem_q;
	assign div_out   = div_q;
	assign quot_out  = quot_q;
	assign flags_out = flags_q;

endmodule

// File: src/iad_back.sv
// ----------------------------------------------------------------------------
// iad_back
// Stepped correction, octant mirror, quadrant placement, output register.
// ----------------------------------------------------------------------------
module iad_back #(
	parameter int COORD_WIDTH = iad_pkg::COORD_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  logic [COORD_WIDTH-1:0]            div_in,
	input  logic [iad_pkg::QUOT_W-1:0]        quot_in,
	input  iad_pkg::iad_flags_t               flags_in,
	output logic                              out_valid,
	output logic [iad_pkg::ANGLE_W-1:0]       angle
);

	logic [2:0]                   corr;
	logic [iad_pkg::OCT_W-1:0]    oct;
	logic [iad_pkg::OCT_W-1:0]    folded;
	logic [iad_pkg::ANGLE_W-1:0]  fold_ext;
	logic [iad_pkg::ANGLE_W-1:0]  placed;

	always_comb begin
		corr = 3'd0;
		if (quot_in > iad_pkg::SPLIT) begin
			corr = 3'(quot_in <= iad_pkg::HI_TH_0) + 3'(quot_in <= iad_pkg::HI_TH_1)
				+ 3'(quot_in <= iad_pkg::HI_TH_2) + 3'(quot_in <= iad_pkg::HI_TH_3);
		end else begin
			corr = 3'(quot_in >= iad_pkg::LO_TH_0) + 3'(quot_in >= iad_pkg::LO_TH_1)
				+ 3'(quot_in >= iad_pkg::LO_TH_2) + 3'(quot_in >= iad_pkg::LO_TH_3);
		end
	end

	assign oct      = {1'b0, quot_in} + {{(iad_pkg::OCT_W-3){1'b0}}, corr};
	assign folded   = flags_in.mirror ? (iad_pkg::DEG_90 - oct) : oct;
	assign fold_ext = {{(iad_pkg::ANGLE_W-iad_pkg::OCT_W){1'b0}}, folded};

	always_comb begin
		case ({flags_in.y_neg, flags_in.x_neg})
			2'b00:   placed = fold_ext;
			2'b01:   placed = iad_pkg::DEG_360 - fold_ext;
			2'b10:   placed = iad_pkg::DEG_180 - fold_ext;
			2'b11:   placed = iad_pkg::DEG_180 + fold_ext;
			default: placed = fold_ext;
		endcase
		// A zero vector has no direction; it reports zero.
		if (div_in == '0) begin
			placed = '0;
		end
	end

	logic                        valid_q;
	logic [iad_pkg::ANGLE_W-1:0] angle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle_q <= placed;
		end
	end

	assign out_valid = valid_q;
	assign angle     = angle_q;

endmodule

// File: src/integer_atan2_degrees_unit.sv
// Each input passes the front stages, the division cells, then the output register.
// Throughput: one item per cycle unless stalled; the six-cell divider chain keeps pace.
// The whole pipeline advances together and holds only while a result waits unaccepted.
// Reset (arst_n low, asynchronous) clears every stage valid bit; data registers keep
// whatever they held, and the unit is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
// integer_atan2_degrees_unit
// Approximate four-quadrant angle in whole degrees, 0 to 360, from a signed
// x/y pair. The ratio min * 45 / max is formed by a row of restoring
// division cells, one quotient bit per cell, then corrected, mirrored
// and placed in its quadrant.
// ----------------------------------------------------------------------------
module integer_atan2_degrees_unit #(
	parameter int COORD_WIDTH = iad_pkg::COORD_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  logic signed [COORD_WIDTH-1:0]     x_value,
	input  logic signed [COORD_WIDTH-1:0]     y_value,
	output logic                              res_valid,
	input  logic                              res_ready,
	output logic [iad_pkg::ANGLE_W-1:0]       angle_degrees
);

	localparam int NUM_W  = COORD_WIDTH + iad_pkg::QUOT_W;
	localparam int CELLS  = iad_pkg::QUOT_W;

	// Every stage moves when the output register is empty or its result is
	// being taken in this cycle, so req_ready follows res_ready directly while a result waits.
	logic en;
	assign en        = !res_valid || res_ready;
	assign req_ready = en;

	// Signals between the cells: index k feeds cell k, index k+1 leaves it.
	logic                       valid_c [0:CELLS];
	logic [NUM_W-1:0]           rem_c   [0:CELLS-1];
	logic [COORD_WIDTH-1:0]     div_c   [0:CELLS];
	logic [iad_pkg::QUOT_W-1:0] quot_c  [0:CELLS];
	iad_pkg::iad_flags_t        flags_c [0:CELLS];

	iad_front #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (req_valid),
		.x_value  (x_value),
		.y_value  (y_value),
		.out_valid(valid_c[0]),
		.num      (rem_c[0]),
		.div      (div_c[0]),
		.flags    (flags_c[0])
	);

	assign quot_c[0] = '0;

	// The first cell settles the most significant quotient bit. The last
	// cell's remainder is not needed beyond the chain.
	for (genvar k = 0; k < CELLS; k++) begin : g_cell
		if (k < CELLS - 1) begin : g_mid
			iad_cell #(
				.COORD_WIDTH(COORD_WIDTH),
				.BIT_POS    (CELLS - 1 - k)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.en       (en),
				.in_valid (valid_c[k]),
				.rem_in   (rem_c[k]),
				.div_in   (div_c[k]),
				.quot_in  (quot_c[k]),
				.flags_in (flags_c[k]),
				.out_valid(valid_c[k+1]),
				.rem_out  (rem_c[k+1]),
				.div_out  (div_c[k+1]),
				.quot_out (quot_c[k+1]),
				.flags_out(flags_c[k+1])
			);
		end else begin : g_last
			iad_cell #(
				.COORD_WIDTH(COORD_WIDTH),
				.BIT_POS    (CELLS - 1 - k)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.en       (en),
				.in_valid (valid_c[k]),
				.rem_in   (rem_c[k]),
				.div_in   (div_c[k]),
				.quot_in  (quot_c[k]),
				.flags_in (flags_c[k]),
				.out_valid(valid_c[k+1]),
				.rem_out  (),
				.div_out  (div_c[k+1]),
				.quot_out (quot_c[k+1]),
				.flags_out(flags_c[k+1])
			);
		end
	end

	// Correction, mirroring and quadrant placement feed the output register.
	iad_back #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (valid_c[CELLS]),
		.div_in   (div_c[CELLS]),
		.quot_in  (quot_c[CELLS]),
		.flags_in (flags_c[CELLS]),
		.out_valid(res_valid),
		.angle    (angle_degrees)
	);

endmodule

// File: tb/tb_integer_atan2_degrees_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_integer_atan2_degrees_unit
// Self-checking bench for the integer atan2 unit. Every accepted x/y pair is
// run through a local angle predictor. Each returned angle is checked in
// order against that prediction while both handshakes idle at random or, in some phases, never idle.
// ----------------------------------------------------------------------------
module tb_integer_atan2_degrees_unit;

	localparam int CW      = iad_pkg::COORD_WIDTH_DEF;
	localparam int ANGLE_W = iad_pkg::ANGLE_W;
	localparam int OCT_W   = iad_pkg::OCT_W;

	// The pipeline is nine stages deep. These margins sit well above that,
	// above the longest sender gap, and above the longest result stall.
	localparam int DRAIN_CYCLES = 16;
	localparam int STALL_LIMIT  = 1000;

	// One outstanding prediction. The input pair is kept so that a mismatch
	// report can say which vector went wrong.
	typedef struct {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic [ANGLE_W-1:0]   angle;
	} pending_angle_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_ready;
	logic signed [CW-1:0] x_value = '0;
	logic signed [CW-1:0] y_value = '0;
	logic                 res_valid;
	logic                 res_ready = 1'b0;
	logic [ANGLE_W-1:0]   angle_degrees;

	pending_angle_t expected_angles[$];
	int mismatch_count = 0;
	int sent_count = 0;
	int checked_count = 0;
	// Percent odds of idling. Zero gives stretches where both sides run flat out.
	int idle_pct = 0;
	int stall_left = 0;
	int quiet_cycles = 0;

	integer_atan2_degrees_unit #(
		.COORD_WIDTH(CW)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.x_value(x_value),
		.y_value(y_value),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.angle_degrees(angle_degrees)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Angle predictor. It takes both magnitudes and forms the ratio
	// min * 45 / max, which rounds down. It adds the stepped correction and
	// mirrors about 45 degrees when |x| > |y|. It then places the angle in
	// its quadrant from the two signs. The magnitudes are held in int, so the
	// most negative input yields 2^(CW-1) exactly.
	function automatic logic [ANGLE_W-1:0] predict_angle(logic signed [CW-1:0] x,
			logic signed [CW-1:0] y);
		int mag_x;
		int mag_y;
		int ratio;
		int bump;
		bit flip;
		logic [OCT_W-1:0] octant;
		mag_x = (x < 0) ? -int'(x) : int'(x);
		mag_y = (y < 0) ? -int'(y) : int'(y);
		// The origin has no direction. The unit reports zero there.
		if (mag_x == 0 && mag_y == 0)
			return '0;
		flip = (mag_x > mag_y);
		ratio = flip ? (mag_y * 45) / mag_x : (mag_x * 45) / mag_y;
		bump = 0;
		if (ratio > int'(iad_pkg::SPLIT)) begin
			// Upper half: one degree for each high threshold not exceeded.
			bump += (ratio <= int'(iad_pkg::HI_TH_0));
			bump += (ratio <= int'(iad_pkg::HI_TH_1));
			bump += (ratio <= int'(iad_pkg::HI_TH_2));
			bump += (ratio <= int'(iad_pkg::HI_TH_3));
		end else begin
			// Lower half: one degree for each low threshold reached.
			bump += (ratio >= int'(iad_pkg::LO_TH_0));
			bump += (ratio >= int'(iad_pkg::LO_TH_1));
			bump += (ratio >= int'(iad_pkg::LO_TH_2));
			bump += (ratio >= int'(iad_pkg::LO_TH_3));
		end
		octant = OCT_W'(ratio + bump);
		if (flip)
			octant = iad_pkg::DEG_90 - octant;
		if (y < 0)
			return (x < 0) ? iad_pkg::DEG_180 + ANGLE_W'(octant)
				: iad_pkg::DEG_180 - ANGLE_W'(octant);
		if (x < 0)
			return iad_pkg::DEG_360 - ANGLE_W'(octant);
		return ANGLE_W'(octant);
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	// Presents one vector and holds it until the unit takes it. When idling is
	// enabled, a random gap with valid low may come first. The task returns
	// in the time step of the transfer edge. The next call then either keeps
	// valid high or lowers it, with one assignment in that step.
	task automatic send_vector(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y);
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		req_valid <= 1'b1;
		x_value <= x;
		y_value <= y;
		do
			@(posedge clk);
		while (!req_ready);
	endtask

	// Sends a vector together with its reflections in both axes.
	task automatic send_all_quadrants(input logic signed [CW-1:0] x,
			input logic signed [CW-1:0] y);
		send_vector(x, y);
		send_vector(-x, y);
		send_vector(x, -y);
		send_vector(-x, -y);
	endtask

	// Result side. It stalls in bursts of random length. Each burst is
	// decided on a cycle where no stall is running. Only one assignment to
	// ready is made per edge.
	always @(posedge clk) begin
		if (stall_left == 0 && idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 2)
			stall_left = $urandom_range(1, 7);
		if (stall_left > 0) begin
			stall_left--;
			res_ready <= 1'b0;
		end else begin
			res_ready <= 1'b1;
		end
	end

	// Scoreboard. Both channels are sampled at the same edge. Inputs and
	// outputs change only through nonblocking updates, so the values read
	// here are the ones from before the edge. The prediction is queued
	// before the result check runs. Since the pipeline registers every item, a
	// result never races its own prediction.
	always @(posedge clk) begin
		pending_angle_t want;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				want.x = x_value;
				want.y = y_value;
				want.angle = predict_angle(x_value, y_value);
				expected_angles.push_back(want);
				sent_count++;
			end
			if (res_valid && res_ready) begin
				checked_count++;
				if (expected_angles.size() == 0) begin
					report_mismatch($sformatf("angle %0d returned with nothing pending",
						angle_degrees));
				end else begin
					want = expected_angles.pop_front();
					if (angle_degrees !== want.angle)
						report_mismatch($sformatf("x=%0d y=%0d angle_degrees=%0d, want %0d",
							want.x, want.y, angle_degrees, want.angle));
				end
			end
		end
	end

	// Watchdog. A run where neither channel completes a transfer for this
	// long is hung.
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (res_valid && res_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("watchdog: %0d cycles without a transfer", STALL_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Origin, the four half axes at unit and full scale, and the most
	// negative value on each axis.
	task automatic test_origin_and_axes();
		send_vector(0, 0);
		send_vector(1, 0);
		send_vector(0, 1);
		send_vector(-1, 0);
		send_vector(0, -1);
		send_vector(16'sh7FFF, 0);
		send_vector(0, 16'sh7FFF);
		send_vector(16'sh8000, 0);
		send_vector(0, 16'sh8000);
	endtask

	// Equal magnitudes give a raw ratio of 45 with no correction and no
	// mirroring. The extremes of both fields are included.
	task automatic test_diagonals();
		send_vector(1, 1);
		send_vector(-5, 5);
		send_vector(7, -7);
		send_vector(16'sh7FFF, 16'sh7FFF);
		send_vector(16'sh8000, 16'sh8000);
	endtask

	// With the larger magnitude at 45, the raw ratio equals the smaller
	// magnitude. Values are placed on each correction threshold and on the
	// split between the halves. The pairs alternate between mirrored and
	// unmirrored and move through all four quadrants.
	task automatic test_correction_steps();
		int steps[11] = '{1, 2, 6, 10, 15, 22, 23, 32, 37, 41, 44};
		foreach (steps[i]) begin
			case (i % 4)
				0: send_vector(CW'(steps[i]), 45);
				1: send_vector(-45, CW'(steps[i]));
				2: send_vector(CW'(-steps[i]), -45);
				default: send_vector(45, CW'(-steps[i]));
			endcase
		end
	endtask

	// Random vectors in several shapes. The shapes are full-range words,
	// small magnitudes, and pairs near the diagonal. They also include
	// mixes of extreme values, and pairs built to hit a chosen raw ratio.
	// Signs and order are randomized for every shape.
	task automatic test_random_vectors(input int count, input int idle_odds);
		logic signed [CW-1:0] a;
		logic signed [CW-1:0] b;
		logic signed [CW-1:0] corner[5] = '{16'sh8000, 16'sh7FFF, -1, 0, 1};
		int hi;
		idle_pct = idle_odds;
		repeat (count) begin
			case ($urandom_range(0, 4))
				0: begin
					a = CW'($urandom);
					b = CW'($urandom);
				end
				1: begin
					a = CW'($urandom_range(0, 128) - 64);
					b = CW'($urandom_range(0, 128) - 64);
				end
				2: begin
					a = CW'($urandom);
					b = a + CW'($urandom_range(0, 8) - 4);
				end
				3: begin
					a = corner[$urandom_range(0, 4)];
					b = corner[$urandom_range(0, 4)];
				end
				default: begin
					hi = $urandom_range(45, 32768);
					a = CW'(hi);
					b = CW'((hi * $urandom_range(0, 45)) / 45);
				end
			endcase
			if ($urandom_range(0, 1))
				a = -a;
			if ($urandom_range(0, 1))
				b = -b;
			if ($urandom_range(0, 1))
				send_vector(a, b);
			else
				send_vector(b, a);
		end
	endtask

	initial begin
		// Reset is held low from the start. It is released on a rising edge, and
		// the unit then takes transfers from the following cycle.
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 30;
		test_origin_and_axes();
		test_diagonals();
		test_correction_steps();
		send_all_quadrants(3, 40);
		test_random_vectors(140, 30);
		test_random_vectors(60, 0);
		test_random_vectors(140, 60);
		// The last stretch runs with both sides always ready.
		test_random_vectors(60, 0);
		req_valid <= 1'b0;

		// Drain. The watchdog bounds this wait. The extra cycles after it
		// catch any result that arrives late.
		while (expected_angles.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered: origin, axes, diagonals, correction thresholds, all quadrants");
		$display("vectors sent %0d, angles checked %0d, mismatches %0d",
			sent_count, checked_count, mismatch_count);
		if (mismatch_count == 0 && expected_angles.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: sim.f
src/iad_pkg.sv
src/iad_front.sv
src/iad_cell.sv
src/iad_back.sv
src/integer_atan2_degrees_unit.sv
tb/tb_integer_atan2_degrees_unit.sv
